FILE: rtl/pic_pkg.sv
// Package for the platform interrupt controller: constants, codes and types
// shared by the controller, datapath and top level. No dependencies.
package pic_pkg;

  localparam int NumSourcesDef  = 32;
  localparam int NumContextsDef = 2;

  localparam logic [25:0] PendBase   = 26'h0001000;
  localparam logic [25:0] EnabBase   = 26'h0002000;
  localparam logic [25:0] ThrBase    = 26'h0200000;
  localparam int          EnabStride = 'h80;
  localparam int          ThrStride  = 'h1000;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_PRIO, K_PEND, K_ENAB, K_THR, K_CLAIM, K_BAD
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_SCAN, ST_CLAIM, ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan_start;
    logic scan_step;
    logic claim;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_claim;
    logic scan_last;
  } dp_sts_t;

endpackage

FILE: rtl/platform_interrupt_controller_unit.sv
// Platform-level interrupt controller with machine and supervisor contexts.
// Each item is a bus read, a bus write, or a sample of the source lines.
// The in_ channel takes an item when in_valid is high and in_stall low; the
// out_ channel gives one result item per input item under the same rule.
// A plain item is executed in ST_EXEC, then scanned one source priority per
// cycle in ST_SCAN, and out_valid rises in ST_DONE (a claim read first scans
// in ST_CLAIM to pick, then once more in ST_SCAN for meip/seip).
// One item is in flight at a time; in_stall stays high until its result
// has been taken, so no new item is taken before the last one is through.
// meip and seip give whether context 0 and 1 have a claimable source after
// the item. A stalled result holds its value until taken.
// Reset clears all priorities, enables, thresholds, pending and gateway
// bits, and leaves the block ready for an item.
// Depends on pic_pkg, pic_ctrl and pic_dp.
module platform_interrupt_controller_unit #(
  parameter int NUM_SOURCES  = pic_pkg::NumSourcesDef,
  parameter int NUM_CONTEXTS = pic_pkg::NumContextsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [25:0] in_offset,
  input  logic [3:0]  in_access_bytes,
  input  logic [31:0] in_write_data,
  input  logic [31:0] in_irq_lines,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_data,
  output logic        out_access_error,
  output logic        out_meip,
  output logic        out_seip
);
  import pic_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  pic_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .sts
  );

  pic_dp #(.NumSources(NUM_SOURCES), .NumContexts(NUM_CONTEXTS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_opcode, .in_offset, .in_access_bytes,
    .in_write_data, .in_irq_lines, .out_read_data, .out_access_error,
    .out_meip, .out_seip
  );

`ifndef SYNTHESIS
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("item taken while result waits");
  a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_access_error) |-> out_read_data == 32'd0)
    else $error("error result carries data");
  a_one_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !out_valid) else $error("result too early");
`endif
endmodule

FILE: rtl/pic_ctrl.sv
// Sequencer of the interrupt controller: item handshake and scan control.
// Depends on pic_pkg.
module pic_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output pic_pkg::ctl_cmd_t cmd,
  input  pic_pkg::dp_sts_t  sts
);
  import pic_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.is_claim) begin
          cmd.scan_start = 1'b1;
          state_nxt      = ST_CLAIM;
        end else begin
          cmd.exec       = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_CLAIM: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          cmd.claim      = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_DONE;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

FILE: rtl/pic_dp.sv
// Datapath of the interrupt controller: decode, register file, gateways and
// the one-source-per-cycle priority scan for every context. Depends on pic_pkg.
module pic_dp #(
  parameter int NumSources  = pic_pkg::NumSourcesDef,
  parameter int NumContexts = pic_pkg::NumContextsDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pic_pkg::ctl_cmd_t cmd,
  output pic_pkg::dp_sts_t  sts,
  input  logic [1:0]        in_opcode,
  input  logic [25:0]       in_offset,
  input  logic [3:0]        in_access_bytes,
  input  logic [31:0]       in_write_data,
  input  logic [31:0]       in_irq_lines,
  output logic [31:0]       out_read_data,
  output logic              out_access_error,
  output logic              out_meip,
  output logic              out_seip
);
  import pic_pkg::*;

  localparam int SrcW = (NumSources > 1) ? $clog2(NumSources) : 1;
  localparam int CtxW = $clog2(NumContexts);

  logic [1:0]  op_r;
  logic [25:0] off_r;
  logic [3:0]  bytes_r;
  logic [31:0] wd_r;
  logic [31:0] lines_r;

  logic [31:0]           prio_r [NumSources];
  logic [NumSources-1:0] pend_r, busy_r;
  logic [NumSources-1:0] en_r   [NumContexts];
  logic [31:0]           thr_r  [NumContexts];

  logic [SrcW-1:0]       scan_r;
  logic [SrcW-1:0]       best_r [NumContexts];
  logic [31:0]           bestp_r [NumContexts];
  logic [NumContexts-1:0] hit_r;
  logic [31:0]           rd_r;
  logic                  err_r;

  logic [SrcW-1:0]        best_now [NumContexts];
  logic [NumContexts-1:0] hit_now;

  kind_t          kind;
  logic [CtxW-1:0] ctx;
  logic [SrcW-1:0] pidx;
  logic [25:0]    rel;

  always_comb begin
    kind = K_BAD;
    ctx  = '0;
    pidx = off_r[SrcW+1:2];
    rel  = '0;
    if (bytes_r == 4'd4) begin
      if (off_r < 26'(NumSources * 4)) begin
        kind = K_PRIO;
      end else if (off_r[25:2] == PendBase[25:2]) begin
        kind = K_PEND;
      end else if (off_r >= EnabBase && off_r < ThrBase) begin
        rel = off_r - EnabBase;
        if (rel[25:7] < 19'(NumContexts) && rel[6:2] == '0) begin
          kind = K_ENAB;
          ctx  = rel[7 +: CtxW];
        end
      end else if (off_r >= ThrBase) begin
        rel = off_r - ThrBase;
        if (rel[25:12] < 14'(NumContexts)) begin
          ctx = rel[12 +: CtxW];
          if (rel[11:2] == 10'd0)      kind = K_THR;
          else if (rel[11:2] == 10'd1) kind = K_CLAIM;
        end
      end
    end
  end

  assign sts.is_claim  = (op_r == OP_READ) && (kind == K_CLAIM);
  assign sts.scan_last = (scan_r == SrcW'(NumSources - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_opcode;
      off_r   <= in_offset;
      bytes_r <= in_access_bytes;
      wd_r    <= in_write_data;
      lines_r <= in_irq_lines;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      busy_r <= '0;
      for (int i = 0; i < NumSources; i++) prio_r[i] <= '0;
      for (int c = 0; c < NumContexts; c++) begin
        en_r[c]  <= '0;
        thr_r[c] <= '0;
      end
    end else begin
      if (cmd.exec) begin
        if (op_r == OP_WRITE && kind != K_BAD) begin
          case (kind)
            K_PRIO: if (pidx != '0) prio_r[pidx] <= wd_r;
            K_ENAB: en_r[ctx] <= wd_r[NumSources-1:0] & ~NumSources'(1);
            K_THR:  thr_r[ctx] <= wd_r;
            K_CLAIM: begin
              if (wd_r < 32'(NumSources)) busy_r[wd_r[SrcW-1:0]] <= 1'b0;
            end
            default: ;
          endcase
        end else if (op_r == OP_SAMPLE) begin
          busy_r <= busy_r | (lines_r[NumSources-1:0] & ~NumSources'(1) & ~busy_r);
          pend_r <= pend_r | (lines_r[NumSources-1:0] & ~NumSources'(1) & ~busy_r);
        end
      end
      if (cmd.claim) pend_r[best_now[ctx]] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_r  <= '0;
      err_r <= 1'b0;
      if ((op_r == OP_READ || op_r == OP_WRITE) && kind == K_BAD) err_r <= 1'b1;
      else if (op_r == OP_READ) begin
        case (kind)
          K_PRIO: rd_r <= prio_r[pidx];
          K_PEND: rd_r <= 32'(pend_r);
          K_ENAB: rd_r <= 32'(en_r[ctx]);
          K_THR:  rd_r <= thr_r[ctx];
          default: ;
        endcase
      end
    end else if (cmd.claim) begin
      rd_r  <= 32'(best_now[ctx]);
      err_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_r <= SrcW'(1);
      for (int c = 0; c < NumContexts; c++) begin
        best_r[c]  <= '0;
        bestp_r[c] <= '0;
      end
    end else if (cmd.scan_step) begin
      scan_r <= scan_r + SrcW'(1);
      for (int c = 0; c < NumContexts; c++) begin
        if (pend_r[scan_r] && en_r[c][scan_r] && prio_r[scan_r] > thr_r[c] &&
            prio_r[scan_r] > bestp_r[c]) begin
          best_r[c]  <= scan_r;
          bestp_r[c] <= prio_r[scan_r];
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NumContexts; c++) begin
      best_now[c] = best_r[c];
      if (pend_r[scan_r] && en_r[c][scan_r] && prio_r[scan_r] > thr_r[c] &&
          prio_r[scan_r] > bestp_r[c]) best_now[c] = scan_r;
      hit_now[c] = (best_now[c] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)          hit_r <= '0;
    else if (cmd.finish) hit_r <= hit_now;
  end

  assign out_read_data    = rd_r;
  assign out_access_error = err_r;
  assign out_meip         = hit_r[0];
  assign out_seip         = hit_r[1];
endmodule

FILE: tb/sv/tb_platform_interrupt_controller_unit.sv
// Testbench for platform_interrupt_controller_unit: bus reads, writes, claims,
// completions and line samples checked against a built-in predictor.
// Depends on pic_pkg and the controller RTL.
module tb_platform_interrupt_controller_unit;
  import pic_pkg::*;

  localparam int NSRC = 32;
  localparam int NCTX = 2;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [31:0] read_data;
    logic        access_error;
    logic        meip;
    logic        seip;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = 2'd0;
  logic [25:0] in_offset = 26'd0;
  logic [3:0]  in_access_bytes = 4'd0;
  logic [31:0] in_write_data = 32'd0;
  logic [31:0] in_irq_lines = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [31:0] out_read_data;
  logic        out_access_error;
  logic        out_meip;
  logic        out_seip;

  logic [31:0] prio_m [NSRC];
  logic [31:0] pending_m;
  logic [31:0] enable_m [NCTX];
  logic [31:0] thresh_m [NCTX];
  logic [31:0] busy_m;

  result_t expected_q[$];
  int      error_count = 0;
  int      sent_count = 0;
  int      checked_count = 0;
  int      claim_count = 0;
  int      idle_cycles = 0;
  bit      sender_bursty = 1'b1;

  platform_interrupt_controller_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] best_source(int ctx);
    logic [31:0] ep;
    logic [31:0] best;
    logic [31:0] bestp;
    ep = pending_m & enable_m[ctx];
    best = 0;
    bestp = 0;
    for (int i = 1; i < NSRC; i++) begin
      if (ep[i] && prio_m[i] > 0 && prio_m[i] > thresh_m[ctx] && prio_m[i] > bestp) begin
        best = i;
        bestp = prio_m[i];
      end
    end
    return best;
  endfunction

  function automatic kind_t decode_offset(logic [25:0] off, logic [3:0] nbytes, output int idx);
    logic [31:0] r;
    int c;
    idx = 0;
    if (nbytes != 4) return K_BAD;
    if (off < NSRC * 4) begin
      idx = off / 4;
      return K_PRIO;
    end
    if (off >= PendBase && off < PendBase + 4) return K_PEND;
    if (off >= EnabBase && off < ThrBase) begin
      r = off - EnabBase;
      c = r / EnabStride;
      if (c >= NCTX || (r % EnabStride) / 4 != 0) return K_BAD;
      idx = c;
      return K_ENAB;
    end
    if (off >= ThrBase) begin
      r = off - ThrBase;
      c = r / ThrStride;
      if (c >= NCTX) return K_BAD;
      idx = c;
      if ((r % ThrStride) / 4 == 0) return K_THR;
      if ((r % ThrStride) / 4 == 1) return K_CLAIM;
    end
    return K_BAD;
  endfunction

  function automatic result_t predict_access(op_t op, logic [25:0] off, logic [3:0] nbytes,
                                             logic [31:0] wd, logic [31:0] lines);
    result_t res;
    kind_t   k;
    int      idx;
    res = '0;
    if (op == OP_READ || op == OP_WRITE) begin
      k = decode_offset(off, nbytes, idx);
      if (k == K_BAD) begin
        res.access_error = 1'b1;
      end else if (op == OP_READ) begin
        case (k)
          K_PRIO: res.read_data = prio_m[idx];
          K_PEND: res.read_data = pending_m;
          K_ENAB: res.read_data = enable_m[idx];
          K_THR:  res.read_data = thresh_m[idx];
          default: begin
            res.read_data = best_source(idx);
            pending_m[res.read_data[4:0]] = 1'b0;
            if (res.read_data != 0) claim_count++;
          end
        endcase
      end else begin
        case (k)
          K_PRIO: prio_m[idx] = wd;
          K_PEND: ;
          K_ENAB: enable_m[idx] = wd;
          K_THR:  thresh_m[idx] = wd;
          default: if (wd < NSRC) busy_m[wd[4:0]] = 1'b0;
        endcase
        prio_m[0] = 0;
        for (int i = 0; i < NCTX; i++) enable_m[i][0] = 1'b0;
      end
    end else if (op == OP_SAMPLE) begin
      lines[0] = 1'b0;
      lines = lines & ~busy_m;
      busy_m |= lines;
      pending_m |= lines;
    end
    res.meip = best_source(0) != 0;
    res.seip = best_source(1) != 0;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH item %0d %s: got %h expected %h", checked_count, what, got, want);
    error_count++;
  endtask

  task automatic send_item(op_t op, logic [25:0] off, logic [3:0] nbytes = 4,
                           logic [31:0] wd = 0, logic [31:0] lines = 0);
    if (sender_bursty && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_offset <= off;
    in_access_bytes <= nbytes;
    in_write_data <= wd;
    in_irq_lines <= lines;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(predict_access(op, off, nbytes, wd, lines));
    sent_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall || out_valid && !out_stall) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding", expected_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", out_read_data, 0);
        end else begin
          result_t want;
          want = expected_q.pop_front();
          if (out_read_data !== want.read_data)
            report_mismatch("read_data", out_read_data, want.read_data);
          if (out_access_error !== want.access_error)
            report_mismatch("access_error", out_access_error, want.access_error);
          if (out_meip !== want.meip) report_mismatch("meip", out_meip, want.meip);
          if (out_seip !== want.seip) report_mismatch("seip", out_seip, want.seip);
        end
        checked_count++;
      end
      case ((checked_count / 64) % 3)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  function automatic logic [25:0] claim_offset(int ctx);
    return 26'(ThrBase + ctx * ThrStride + 4);
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_item(OP_READ, 0);
    send_item(OP_WRITE, 0, 4, 32'hFFFF_FFFF);
    send_item(OP_WRITE, 31 * 4 + 3, 4, 32'hFFFF_FFFF);
    send_item(OP_READ, 31 * 4);
    send_item(OP_WRITE, 4, 4, 32'd5);
    send_item(OP_WRITE, 8, 4, 32'd5);
    send_item(OP_WRITE, EnabBase, 4, 32'hFFFF_FFFF);
    send_item(OP_WRITE, 26'(EnabBase + EnabStride), 4, 32'hFFFF_FFFF);
    send_item(OP_READ, EnabBase);
    send_item(OP_WRITE, 26'(ThrBase + ThrStride), 4, 32'd5);
    send_item(OP_SAMPLE, 0, 4, 0, 32'hFFFF_FFFF);
    send_item(OP_READ, PendBase);
    send_item(OP_WRITE, PendBase, 4, 32'hFFFF_FFFF);
    send_item(OP_READ, claim_offset(0));
    send_item(OP_READ, claim_offset(0));
    send_item(OP_READ, claim_offset(1));
    send_item(OP_WRITE, claim_offset(0), 4, 32'd31);
    send_item(OP_WRITE, claim_offset(0), 4, 32'd32);
    send_item(OP_WRITE, claim_offset(0), 4, 32'd7);
    send_item(OP_READ, 0, 8);
    send_item(OP_READ, 26'h3FF_FFFF);
    send_item(OP_READ, 26'(EnabBase + 4));
    send_item(OP_READ, 26'(ThrBase + 2 * ThrStride));
    send_item(OP_READ, 26'(ThrBase + 8));
    send_item(OP_NONE, 26'h3FF_FFFF, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_pause_until_drained();
    wait_drained();
    send_item(OP_READ, 26'(ThrBase + ThrStride));
    wait_drained();
  endtask

  task automatic test_random_flow(int count);
    int pick;
    int ctx;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      ctx = $urandom_range(0, NCTX - 1);
      sender_bursty = (n / 200) % 2 == 0;
      if (pick < 12) begin
        send_item(OP_WRITE, 26'($urandom_range(0, NSRC - 1) * 4 + $urandom_range(0, 3)), 4,
                  $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom());
      end else if (pick < 16) begin
        send_item(OP_WRITE, 26'(EnabBase + ctx * EnabStride), 4, $urandom());
      end else if (pick < 20) begin
        send_item(OP_WRITE, 26'(ThrBase + ctx * ThrStride), 4,
                  $urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom());
      end else if (pick < 40) begin
        send_item(OP_SAMPLE, 26'($urandom()), 4'($urandom()), $urandom(), $urandom());
      end else if (pick < 62) begin
        send_item(OP_READ, claim_offset(ctx));
      end else if (pick < 80) begin
        send_item(OP_WRITE, claim_offset(ctx), 4,
                  $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 33));
      end else if (pick < 90) begin
        case ($urandom_range(0, 3))
          0: send_item(OP_READ, 26'(PendBase + $urandom_range(0, 3)));
          1: send_item(OP_READ, 26'(EnabBase + ctx * EnabStride + $urandom_range(0, 3)));
          2: send_item(OP_READ, 26'(ThrBase + ctx * ThrStride + $urandom_range(0, 3)));
          default: send_item(OP_READ, 26'($urandom_range(0, NSRC * 4 - 1)));
        endcase
      end else begin
        send_item(op_t'($urandom_range(0, 3)), 26'($urandom()), 4'($urandom()), $urandom(),
                  $urandom());
      end
    end
    sender_bursty = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < NSRC; i++) prio_m[i] = 0;
    for (int i = 0; i < NCTX; i++) begin
      enable_m[i] = 0;
      thresh_m[i] = 0;
    end
    pending_m = 0;
    busy_m = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_pause_until_drained();
    test_random_flow(1720);
    wait_drained();
    repeat (2 * NSRC + 10) @(posedge clk);
    $display("Sent %0d items, checked %0d results, %0d nonzero claims", sent_count,
             checked_count, claim_count);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

FILE: platform_interrupt_controller_unit.f
rtl/pic_pkg.sv
rtl/pic_ctrl.sv
rtl/pic_dp.sv
rtl/platform_interrupt_controller_unit.sv
tb/sv/tb_platform_interrupt_controller_unit.sv
